// ----- rtl/rdz_pkg.sv -----
`timescale 1ns / 1ps

package rdz_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAG_W       = SAMPLE_BITS + 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int FRAC_BITS   = 8;
  localparam int RAD_W       = SQ_W + 2 * FRAC_BITS;
  localparam int RT_W        = RAD_W / 2;
  localparam int DZ_W        = 15;
  localparam int ONE_SHIFT   = 15;
  localparam int OUT_W       = 17;
  localparam int DEN_W       = DZ_W + RT_W;
  localparam int Q_W         = 18;
  localparam int REM_W       = MAG_W + RT_W + ONE_SHIFT + 1;
  localparam int LATENCY     = 3 + RT_W + 2 + Q_W + 1;

  localparam logic [DZ_W-1:0]  FULL_SCALE  = DZ_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [DZ_W-1:0]  DZ_RESET    = DZ_W'(2294);
  localparam logic [Q_W-1:0]   OUT_MAX     = Q_W'(49151);
  localparam logic [Q_W-1:0]   OUT_MIN_MAG = Q_W'(49152);

  // control and per-request sideband that travels with each pipeline stage
  typedef struct packed {
    logic             valid;
    logic             active;
    logic             nx;
    logic             ny;
    logic             tag;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } side_t;

endpackage

// ----- rtl/rdz_sqrt.sv -----
`timescale 1ns / 1ps

// bit-serial pipelined square root, one root bit per stage
module rdz_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rdz_pkg::RAD_W-1:0]   rad_i,
  input  rdz_pkg::side_t              side_i,
  output logic [rdz_pkg::RT_W-1:0]    root_o,
  output rdz_pkg::side_t              side_o
);

  localparam int RAD_W = rdz_pkg::RAD_W;
  localparam int RT_W  = rdz_pkg::RT_W;

  logic [RAD_W-1:0]   rad_q  [RT_W];
  logic [RT_W+1:0]    rem_q  [RT_W];
  logic [RT_W-1:0]    root_q [RT_W];
  rdz_pkg::side_t     side_q [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_st
    logic [RAD_W-1:0] rad_in;
    logic [RT_W+1:0]  rem_in;
    logic [RT_W-1:0]  root_in;
    rdz_pkg::side_t   side_in;
    logic [RT_W+1:0]  r2;
    logic [RT_W+1:0]  trial;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign r2    = {rem_in[RT_W-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s] <= {rad_in[RAD_W-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_q[s]  <= r2 - trial;
        root_q[s] <= {root_in[RT_W-2:0], 1'b1};
      end else begin
        rem_q[s]  <= r2;
        root_q[s] <= {root_in[RT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[RT_W-1];
  assign side_o = side_q[RT_W-1];

endmodule

// ----- rtl/rdz_div.sv -----
`timescale 1ns / 1ps

// two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage
module rdz_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rdz_pkg::REM_W-1:0]   numx_i,
  input  logic [rdz_pkg::REM_W-1:0]   numy_i,
  input  logic [rdz_pkg::DEN_W-1:0]   den_i,
  input  rdz_pkg::side_t              side_i,
  output logic [rdz_pkg::Q_W-1:0]     qx_o,
  output logic [rdz_pkg::Q_W-1:0]     qy_o,
  output rdz_pkg::side_t              side_o
);

  localparam int REM_W = rdz_pkg::REM_W;
  localparam int DEN_W = rdz_pkg::DEN_W;
  localparam int Q_W   = rdz_pkg::Q_W;

  logic [REM_W-1:0] remx_q [Q_W];
  logic [REM_W-1:0] remy_q [Q_W];
  logic [Q_W-1:0]   qx_q   [Q_W];
  logic [Q_W-1:0]   qy_q   [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];
  rdz_pkg::side_t   side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_st
    logic [REM_W-1:0] remx_in;
    logic [REM_W-1:0] remy_in;
    logic [Q_W-1:0]   qx_in;
    logic [Q_W-1:0]   qy_in;
    logic [DEN_W-1:0] den_in;
    rdz_pkg::side_t   side_in;
    logic [REM_W-1:0] cmp;

    if (s == 0) begin : g_first
      assign remx_in = numx_i;
      assign remy_in = numy_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign remx_in = remx_q[s-1];
      assign remy_in = remy_q[s-1];
      assign qx_in   = qx_q[s-1];
      assign qy_in   = qy_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // divisor aligned to this quotient bit
    assign cmp = REM_W'(den_in) << (Q_W - 1 - s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in;
      if (remx_in >= cmp) begin
        remx_q[s] <= remx_in - cmp;
        qx_q[s]   <= {qx_in[Q_W-2:0], 1'b1};
      end else begin
        remx_q[s] <= remx_in;
        qx_q[s]   <= {qx_in[Q_W-2:0], 1'b0};
      end
      if (remy_in >= cmp) begin
        remy_q[s] <= remy_in - cmp;
        qy_q[s]   <= {qy_in[Q_W-2:0], 1'b1};
      end else begin
        remy_q[s] <= remy_in;
        qy_q[s]   <= {qy_in[Q_W-2:0], 1'b0};
      end
    end
  end

  assign qx_o   = qx_q[Q_W-1];
  assign qy_o   = qy_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule

// ----- rtl/radial_dead_zone_scaler.sv -----
`timescale 1ns / 1ps

// Radial scaled dead zone for a signed stick sample pair. A request is taken on
// every cycle that start is high (busy never rises), so one sample pair per clock
// is sustained. Each request gives one result, shown for one cycle with
// result_valid_o; the receiver cannot stall and must capture it then. The path
// runs through the pipelined square root (24 stages, one root bit each) and the
// pipelined divider (18 stages, one quotient bit each), plus input, square,
// setup, scale and output registers. Samples whose squared length is at or below
// dead_zone^2, or any sample while dead_zone is 32767, give zeros; others are
// scaled by (mag - dz) / ((32767 - dz) * mag) in a format where 32768 means 1.0,
// truncated toward zero and saturated to -49152..49151. The dead_zone register
// may only be written while no request is in flight; it resets to 2294 and its
// write channel is always ready.
module radial_dead_zone_scaler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rdz_pkg::SAMPLE_BITS-1:0] raw_x_i,
  input  logic signed [rdz_pkg::SAMPLE_BITS-1:0] raw_y_i,
  input  logic                              stick_select_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rdz_pkg::DZ_W-1:0]          cfg_data_i,
  output logic                              result_valid_o,
  output logic signed [rdz_pkg::OUT_W-1:0]  scaled_x_o,
  output logic signed [rdz_pkg::OUT_W-1:0]  scaled_y_o,
  output logic                              stick_tag_o
);

  localparam int SB        = rdz_pkg::SAMPLE_BITS;
  localparam int MAG_W     = rdz_pkg::MAG_W;
  localparam int SQ_W      = rdz_pkg::SQ_W;
  localparam int RAD_W     = rdz_pkg::RAD_W;
  localparam int RT_W      = rdz_pkg::RT_W;
  localparam int DZ_W      = rdz_pkg::DZ_W;
  localparam int DEN_W     = rdz_pkg::DEN_W;
  localparam int REM_W     = rdz_pkg::REM_W;
  localparam int Q_W       = rdz_pkg::Q_W;
  localparam int OUT_W     = rdz_pkg::OUT_W;
  localparam int NUM_W     = MAG_W + RT_W;

  // saturate a quotient magnitude and apply the sign
  function automatic logic [OUT_W-1:0] pack(input logic [Q_W-1:0] q, input logic neg);
    logic [Q_W-1:0] lim;
    if (neg) begin
      lim = (q > rdz_pkg::OUT_MIN_MAG) ? rdz_pkg::OUT_MIN_MAG : q;
      pack = OUT_W'(~lim + Q_W'(1));
    end else begin
      lim = (q > rdz_pkg::OUT_MAX) ? rdz_pkg::OUT_MAX : q;
      pack = OUT_W'(lim);
    end
  endfunction

  // absolute value of a raw sample, full negative value included
  function automatic logic [MAG_W-1:0] mag(input logic [SB-1:0] raw);
    mag = raw[SB-1] ? ({1'b0, ~raw} + MAG_W'(1)) : {1'b0, raw};
  endfunction

  // config register and its square, refreshed every cycle
  logic [DZ_W-1:0]   dz_q;
  logic [2*DZ_W-1:0] dzsq_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= rdz_pkg::DZ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dz_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dzsq_q <= dz_q * dz_q;
  end

  // stage 0: sign and magnitude
  rdz_pkg::side_t s0_q, s0_d;

  always_comb begin
    s0_d        = '0;
    s0_d.valid  = start && !busy;
    s0_d.nx     = raw_x_i[SB-1];
    s0_d.ny     = raw_y_i[SB-1];
    s0_d.tag    = stick_select_i;
    s0_d.ax     = mag(raw_x_i);
    s0_d.ay     = mag(raw_y_i);
  end

  // stage 1: squared length
  rdz_pkg::side_t   s1_q;
  logic [SQ_W-1:0]  s1_sq_q;
  logic [2*MAG_W-1:0] axx, ayy;

  assign axx = s0_q.ax * s0_q.ax;
  assign ayy = s0_q.ay * s0_q.ay;

  // stage 2: dead-zone test, feeds the root pipeline
  rdz_pkg::side_t   s2_q, s2_d;
  logic [SQ_W-1:0]  s2_sq_q;

  always_comb begin
    s2_d        = s1_q;
    s2_d.active = (dz_q < rdz_pkg::FULL_SCALE) && (s1_sq_q > SQ_W'(dzsq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s0_q <= s0_d;
      s1_q <= s0_q;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sq_q <= SQ_W'(axx) + SQ_W'(ayy);
    s2_sq_q <= s1_sq_q;
  end

  // length with eight fraction bits
  logic [RT_W-1:0]  root;
  rdz_pkg::side_t   sr_side;

  rdz_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rad_i  ({s2_sq_q, {(RAD_W-SQ_W){1'b0}}}),
    .side_i (s2_q),
    .root_o (root),
    .side_o (sr_side)
  );

  // p1: numerator term and full-scale span
  rdz_pkg::side_t   p1_q;
  logic [RT_W-1:0]  p1_num_q;
  logic [RT_W-1:0]  p1_root_q;
  logic [DZ_W-1:0]  p1_fs_q;

  // p2: products for divider
  rdz_pkg::side_t   p2_q;
  logic [DEN_W-1:0] p2_den_q;
  logic [NUM_W-1:0] p2_nx_q;
  logic [NUM_W-1:0] p2_ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
    end else begin
      p1_q <= sr_side;
      p2_q <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_num_q  <= root - RT_W'({dz_q, {rdz_pkg::FRAC_BITS{1'b0}}});
    p1_root_q <= root;
    p1_fs_q   <= rdz_pkg::FULL_SCALE - dz_q;
    p2_den_q  <= p1_fs_q * p1_root_q;
    p2_nx_q   <= p1_q.ax * p1_num_q;
    p2_ny_q   <= p1_q.ay * p1_num_q;
  end

  // quotients in the 1.0 = 32768 format
  logic [Q_W-1:0]  qx, qy;
  rdz_pkg::side_t  dv_side;

  rdz_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .numx_i (REM_W'({p2_nx_q, {rdz_pkg::ONE_SHIFT{1'b0}}})),
    .numy_i (REM_W'({p2_ny_q, {rdz_pkg::ONE_SHIFT{1'b0}}})),
    .den_i  (p2_den_q),
    .side_i (p2_q),
    .qx_o   (qx),
    .qy_o   (qy),
    .side_o (dv_side)
  );

  // output register: zero inside the dead zone
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_x_q, out_y_q;
  logic              out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tag_q <= dv_side.tag;
    out_x_q   <= dv_side.active ? pack(qx, dv_side.nx) : '0;
    out_y_q   <= dv_side.active ? pack(qy, dv_side.ny) : '0;
  end

  assign result_valid_o = out_valid_q;
  assign scaled_x_o     = out_x_q;
  assign scaled_y_o     = out_y_q;
  assign stick_tag_o    = out_tag_q;

endmodule

// ----- rtl/rdz_checker.sv -----
`timescale 1ns / 1ps

module rdz_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             stick_select_i,
  input logic                             result_valid_o,
  input logic signed [rdz_pkg::OUT_W-1:0] scaled_x_o,
  input logic signed [rdz_pkg::OUT_W-1:0] scaled_y_o,
  input logic                             stick_tag_o
);

  localparam int LAT = rdz_pkg::LATENCY;

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT result_valid_o)
    else $error("request lost");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LAT))
    else $error("result without request");

  a_tag_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (stick_tag_o == $past(stick_select_i, LAT)))
    else $error("tag mismatch");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (scaled_x_o >= -17'sd49152) && (scaled_y_o >= -17'sd49152)
                       && (scaled_x_o <= 17'sd49151) && (scaled_y_o <= 17'sd49151))
    else $error("result out of range");

endmodule

bind radial_dead_zone_scaler rdz_checker u_rdz_checker (.*);
